[hw/rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next cycle");

`endif

[hw/rtl/i2ra_pkg.sv]
`timescale 1ns / 1ps

package i2ra_pkg;

  // ascii codes and digit limits
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_A      = 8'h41;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [5:0] DIGIT_LIMIT = 6'd9;
  localparam logic [5:0] RADIX_MIN   = 6'd2;
  localparam logic [5:0] RADIX_MAX   = 6'd36;
  localparam logic [6:0] MAX_CHARS_RESET = 7'd34;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_STORE,
    ST_CHECK,
    ST_SIGN,
    ST_READ,
    ST_PUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic store;
    logic emit_ovf;
    logic emit_sign;
    logic read;
    logic emit_digit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_last;
    logic quo_zero;
    logic fits;
    logic neg;
    logic last_digit;
    logic out_free;
  } dp_status_t;

  // digit value to ascii
  function automatic logic [7:0] digit_char(input logic [5:0] d);
    logic [7:0] c;
    if (d > DIGIT_LIMIT) begin
      c = CHAR_A + 8'(d - (DIGIT_LIMIT + 6'd1));
    end else begin
      c = CHAR_ZERO + 8'(d);
    end
    return c;
  endfunction

endpackage

[hw/rtl/i2ra_if.sv]
`timescale 1ns / 1ps

// input item channel
interface i2ra_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic        is_signed;
  logic [5:0]  radix;

  modport source (output valid, value, is_signed, radix, input ready);
  modport sink (input valid, value, is_signed, radix, output ready);
endinterface

// result item channel
interface i2ra_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;
  logic       overflow;
  logic [5:0] char_count;

  modport source (output valid, char_code, last, overflow, char_count, input ready);
  modport sink (input valid, char_code, last, overflow, char_count, output ready);
endinterface

// capacity register write channel
interface i2ra_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[hw/rtl/i2ra_ram.sv]
`timescale 1ns / 1ps

module i2ra_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/i2ra_ctrl.sv]
`timescale 1ns / 1ps

module i2ra_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  i2ra_pkg::dp_status_t status,
  output i2ra_pkg::dp_cmd_t    cmd
);

  import i2ra_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (status.div_last) state_next = ST_STORE;
      end
      ST_STORE: begin
        state_next = status.quo_zero ? ST_CHECK : ST_DIVIDE;
      end
      ST_CHECK: begin
        priority if (!status.fits) begin
          if (status.out_free) state_next = ST_IDLE;
        end else if (status.neg) begin
          state_next = ST_SIGN;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_SIGN: begin
        if (status.out_free) state_next = ST_READ;
      end
      ST_READ: begin
        state_next = ST_PUT;
      end
      ST_PUT: begin
        if (status.out_free) state_next = status.last_digit ? ST_IDLE : ST_READ;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_DIVIDE: cmd.div_step = 1'b1;
      ST_STORE:  cmd.store = 1'b1;
      ST_CHECK:  cmd.emit_ovf = !status.fits && status.out_free;
      ST_SIGN:   cmd.emit_sign = status.out_free;
      ST_READ:   cmd.read = 1'b1;
      ST_PUT:    cmd.emit_digit = status.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

[hw/rtl/i2ra_datapath.sv]
`timescale 1ns / 1ps

module i2ra_datapath #(
  parameter int VALUE_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  i2ra_pkg::dp_cmd_t    cmd,
  output i2ra_pkg::dp_status_t status,
  input  logic [31:0]          in_value,
  input  logic                 in_is_signed,
  input  logic [5:0]           in_radix,
  input  logic                 cfg_we,
  input  logic [6:0]           cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_char_code,
  output logic                 out_last,
  output logic                 out_overflow,
  output logic [5:0]           out_char_count
);

  import i2ra_pkg::*;

  localparam int AW    = $clog2(VALUE_BITS);
  localparam int CW    = $clog2(VALUE_BITS + 1);
  localparam int LEN_W = $clog2(VALUE_BITS + 3);
  localparam int CMP_W = (LEN_W > 7) ? LEN_W : 7;

  logic [VALUE_BITS-1:0] quo;
  logic [5:0]            rem;
  logic [5:0]            radix;
  logic                  neg;
  logic [AW-1:0]         bitcnt;
  logic [CW-1:0]         nd;
  logic [AW-1:0]         rd_idx;
  logic [6:0]            max_chars;

  logic [VALUE_BITS-1:0] v_in;
  logic                  neg_in;
  logic [VALUE_BITS-1:0] mag_in;
  logic [5:0]            radix_in;
  logic [6:0]            r2;
  logic                  ge;
  logic [5:0]            rem_step;
  logic [LEN_W-1:0]      len;
  logic [5:0]            ram_rdata;
  logic                  out_free;

  // operand prep: mask, magnitude, radix clamp
  assign v_in   = VALUE_BITS'(in_value);
  assign neg_in = in_is_signed & v_in[VALUE_BITS-1];
  assign mag_in = neg_in ? (v_in ^ '1) + 1'b1 : v_in;

  always_comb begin
    priority if (in_radix < RADIX_MIN) begin
      radix_in = RADIX_MIN;
    end else if (in_radix > RADIX_MAX) begin
      radix_in = RADIX_MAX;
    end else begin
      radix_in = in_radix;
    end
  end

  // restoring divide step, one quotient bit per cycle
  assign r2       = {rem, quo[VALUE_BITS-1]};
  assign ge       = r2 >= {1'b0, radix};
  assign rem_step = ge ? 6'(r2 - {1'b0, radix}) : r2[5:0];

  // conversion registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bitcnt <= '0;
      nd     <= '0;
      rd_idx <= '0;
    end else begin
      if (cmd.load) begin
        quo    <= mag_in;
        rem    <= '0;
        radix  <= radix_in;
        neg    <= neg_in;
        bitcnt <= '0;
        nd     <= '0;
      end
      if (cmd.div_step) begin
        quo    <= {quo[VALUE_BITS-2:0], ge};
        rem    <= rem_step;
        bitcnt <= bitcnt + 1'b1;
      end
      if (cmd.store) begin
        nd     <= nd + 1'b1;
        rd_idx <= nd[AW-1:0];
        rem    <= '0;
        bitcnt <= '0;
      end
      if (cmd.emit_digit && rd_idx != '0) begin
        rd_idx <= rd_idx - 1'b1;
      end
    end
  end

  // digit store, least significant digit first
  i2ra_ram #(
    .WIDTH (6),
    .DEPTH (VALUE_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (nd[AW-1:0]),
    .wdata (rem),
    .re    (cmd.read),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_chars <= MAX_CHARS_RESET;
    end else if (cfg_we) begin
      max_chars <= cfg_data;
    end
  end

  assign len      = LEN_W'(nd) + LEN_W'(neg);
  assign out_free = !out_valid || out_ready;

  // status back to the controller
  always_comb begin
    status            = '0;
    status.div_last   = bitcnt == AW'(VALUE_BITS - 1);
    status.quo_zero   = quo == '0;
    status.fits       = (CMP_W'(len) + 1'b1) <= CMP_W'(max_chars);
    status.neg        = neg;
    status.last_digit = rd_idx == '0;
    status.out_free   = out_free;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_ovf || cmd.emit_sign || cmd.emit_digit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.emit_ovf) begin
      out_char_code  <= '0;
      out_last       <= 1'b1;
      out_overflow   <= 1'b1;
      out_char_count <= '0;
    end else if (cmd.emit_sign) begin
      out_char_code  <= CHAR_MINUS;
      out_last       <= 1'b0;
      out_overflow   <= 1'b0;
      out_char_count <= '0;
    end else if (cmd.emit_digit) begin
      out_char_code  <= digit_char(ram_rdata);
      out_last       <= rd_idx == '0;
      out_overflow   <= 1'b0;
      out_char_count <= (rd_idx == '0) ? 6'(len) : '0;
    end
  end

endmodule

[hw/rtl/integer_to_radix_ascii.sv]
`timescale 1ns / 1ps

// Converts a value (low VALUE_BITS bits of din.value, two's complement when
// is_signed is set) to ASCII digits in radix 2..36 (out-of-range radix is
// clamped), '0'-'9' then 'A'-'Z', most significant first, with a leading '-'
// for a negative signed value; the last character carries last and the
// character count. If the characters plus a terminator exceed max_chars (reset
// 34), one item with overflow, last, code 0 and count 0 is sent instead.
// One item at a time: a one-bit-per-cycle shared divider produces each digit,
// digits go LSB first into a small RAM, then each digit character is sent in
// two steps (RAM read, output load); the load, and a sign or overflow item,
// wait until the output register is free.
module integer_to_radix_ascii #(
  parameter int VALUE_BITS = 32
) (
  input logic         clk,
  input logic         rst,
  i2ra_in_if.sink     din,
  i2ra_out_if.source  dout,
  i2ra_cfg_if.sink    cfg
);

  import i2ra_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg.ready = 1'b1;

  // sequencer
  i2ra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .in_ready (din.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // divider, digit store and output register
  i2ra_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .in_value       (din.value),
    .in_is_signed   (din.is_signed),
    .in_radix       (din.radix),
    .cfg_we         (cfg.valid),
    .cfg_data       (cfg.data),
    .out_valid      (dout.valid),
    .out_ready      (dout.ready),
    .out_char_code  (dout.char_code),
    .out_last       (dout.last),
    .out_overflow   (dout.overflow),
    .out_char_count (dout.char_count)
  );

endmodule

[hw/rtl/i2ra_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i2ra_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char_code,
  input logic       out_last,
  input logic       out_overflow,
  input logic [5:0] out_char_count
);

  logic        ovf_shape_ok;
  logic        done_char;
  logic [15:0] out_item;

  assign ovf_shape_ok = out_last && out_char_count == 6'd0 && out_char_code == 8'd0;
  assign done_char    = out_valid && out_last && !out_overflow;
  assign out_item     = {out_char_code, out_last, out_overflow, out_char_count};

  // overflow item is a lone, empty last item
  `ASSERT_IMPLIES(a_ovf_shape, clk, rst, out_valid && out_overflow, ovf_shape_ok)

  // count only shows on the last item
  `ASSERT_IMPLIES(a_count_on_last, clk, rst, out_valid && !out_last, out_char_count == 6'd0)

  // a finished conversion has at least one character
  `ASSERT_IMPLIES(a_count_nonzero, clk, rst, done_char, out_char_count != 6'd0)

  // stalled item holds
  `ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_item))

endmodule

bind integer_to_radix_ascii i2ra_checker u_chk (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (dout.valid),
  .out_ready      (dout.ready),
  .out_char_code  (dout.char_code),
  .out_last       (dout.last),
  .out_overflow   (dout.overflow),
  .out_char_count (dout.char_count)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import i2ra_pkg::*;

  localparam int RANDOM_ITEMS   = 40;
  localparam int MAX_GAP        = 10;
  localparam int SETTLE_CYCLES  = 8;
  localparam int END_CYCLES     = 50;
  localparam int HOLD_CYCLES    = 600;
  localparam int WATCHDOG_LIMIT = 20000;

  // one expected character item
  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       ovf;
    logic [5:0] count;
  } char_item_t;

  logic clk = 1'b0;
  logic rst;

  i2ra_in_if  din();
  i2ra_out_if dout();
  i2ra_cfg_if cfg();

  integer_to_radix_ascii i_dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .dout (dout),
    .cfg  (cfg)
  );

  char_item_t expected_chars[$];
  logic [6:0] capacity = MAX_CHARS_RESET;
  int         mismatches = 0;
  int         idle_cycles = 0;
  int         rx_hold_cycles = 0;
  bit         src_idle = 1'b1;
  bit         snk_idle = 1'b1;

  always #5 clk = ~clk;

  // expected characters of one conversion under the current capacity
  function automatic void predict_chars(logic [31:0] num, logic signed_mode,
                                        logic [5:0] radix_in);
    logic [5:0]  base;
    logic [31:0] mag;
    logic        neg;
    logic [5:0]  digits[$];
    int          len;
    char_item_t  item;
    base = (radix_in < RADIX_MIN) ? RADIX_MIN :
           (radix_in > RADIX_MAX) ? RADIX_MAX : radix_in;
    neg = signed_mode && num[31];
    mag = neg ? 32'(-num) : num;
    // digits come out least significant first
    do begin
      digits.push_front(6'(mag % base));
      mag = mag / base;
    end while (mag != 0);
    len = digits.size() + (neg ? 1 : 0);
    if (len + 1 > int'(capacity)) begin
      item = '{code: 8'd0, last: 1'b1, ovf: 1'b1, count: 6'd0};
      expected_chars.push_back(item);
      return;
    end
    if (neg) begin
      item = '{code: CHAR_MINUS, last: 1'b0, ovf: 1'b0, count: 6'd0};
      expected_chars.push_back(item);
    end
    foreach (digits[k]) begin
      item.code = (digits[k] > DIGIT_LIMIT) ? CHAR_A + 8'(digits[k]) - 8'd10
                                            : CHAR_ZERO + 8'(digits[k]);
      item.ovf = 1'b0;
      item.last = (k == digits.size() - 1);
      item.count = item.last ? 6'(len) : 6'd0;
      expected_chars.push_back(item);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // random gap if src_idle, then offer; valid held till stop_input or a gap
  task automatic send_number(input logic [31:0] num, input logic signed_mode,
                             input logic [5:0] radix_in);
    int gap;
    gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      din.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    din.valid     <= 1'b1;
    din.value     <= num;
    din.is_signed <= signed_mode;
    din.radix     <= radix_in;
    do @(posedge clk); while (!din.ready);
    predict_chars(num, signed_mode, radix_in);
  endtask

  task automatic stop_input();
    din.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_for_drain();
    while (expected_chars.size() != 0) @(posedge clk);
  endtask

  // capacity is only changed with the block idle
  task automatic write_capacity(input logic [6:0] cap);
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.data  <= cap;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    capacity = cap;
  endtask

  // field extremes, zero, sign handling, letters and radix saturation
  task automatic test_directed();
    send_number(32'd0, 1'b0, 6'd10);
    send_number(32'd0, 1'b1, 6'd2);
    send_number(32'hFFFF_FFFF, 1'b0, 6'd2);
    send_number(32'hFFFF_FFFF, 1'b1, 6'd10);
    send_number(32'h8000_0000, 1'b1, 6'd2);
    send_number(32'h8000_0000, 1'b1, 6'd10);
    send_number(32'h7FFF_FFFF, 1'b1, 6'd36);
    send_number(32'hFFFF_FFFF, 1'b0, 6'd36);
    send_number(32'd35, 1'b0, 6'd36);
    send_number(32'd10, 1'b0, 6'd11);
    send_number(32'hDEAD_BEEF, 1'b0, 6'd16);
    send_number(32'd123456789, 1'b1, 6'd8);
    send_number(32'd5, 1'b0, 6'd0);
    send_number(32'd5, 1'b0, 6'd1);
    send_number(32'd1295, 1'b0, 6'd37);
    send_number(32'hFFFF_FFF0, 1'b1, 6'd63);
    stop_input();
  endtask

  // capacity sweep including the empty and full register values
  task automatic test_capacity();
    logic [6:0] caps[8] = '{7'd0, 7'd1, 7'd2, 7'd11, 7'd12, 7'd33, 7'd64, 7'd127};
    foreach (caps[i]) begin
      write_capacity(caps[i]);
      send_number(32'd7, 1'b0, 6'd8);
      send_number(32'hFFFF_FFFF, 1'b1, 6'd10);
      send_number(32'h8000_0000, 1'b1, 6'd10);
      send_number(32'hFFFF_FFFF, 1'b0, 6'd2);
      send_number(32'h8000_0000, 1'b1, 6'd2);
      stop_input();
    end
    write_capacity(MAX_CHARS_RESET);
  endtask

  // random values and radices, capacity and idling changed in stretches
  task automatic test_random();
    logic [31:0] num;
    logic [5:0]  radix_in;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 25 == 0 && n != 0) begin
        stop_input();
        write_capacity(($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                   : 7'($urandom_range(8, 40)));
      end
      if (n % 20 == 0) begin
        src_idle = ($urandom_range(0, 2) != 0);
        snk_idle = ($urandom_range(0, 2) != 0);
      end
      case ($urandom_range(0, 3))
        0: num = $urandom_range(0, 40);
        1: num = 32'h7FFF_FFFE + $urandom_range(0, 3);
        2: num = 32'(0 - $urandom_range(1, 40));
        default: num = $urandom();
      endcase
      radix_in = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                             : 6'($urandom_range(2, 36));
      send_number(num, 1'($urandom_range(0, 1)), radix_in);
    end
    stop_input();
    src_idle = 1'b1;
    snk_idle = 1'b1;
  endtask

  // receiver holds off while items keep coming, so the input stalls
  task automatic test_backpressure();
    wait_for_drain();
    src_idle = 1'b0;
    rx_hold_cycles = HOLD_CYCLES;
    for (int n = 0; n < 5; n++) begin
      send_number($urandom(), 1'($urandom_range(0, 1)), 6'd16);
    end
    stop_input();
    src_idle = 1'b1;
  endtask

  // one item at a time, each drained before the next
  task automatic test_lockstep();
    for (int n = 0; n < 6; n++) begin
      send_number($urandom(), 1'($urandom_range(0, 1)), 6'($urandom_range(2, 36)));
      stop_input();
      wait_for_drain();
    end
  endtask

  // result receiver with random stalls and the optional long hold-off
  initial begin
    int stall;
    dout.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (rx_hold_cycles > 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        stall = snk_idle ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (stall > 0) begin
        dout.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      dout.ready <= 1'b1;
      do @(posedge clk); while (!dout.valid);
    end
  end

  // compare each accepted character with the oldest expectation
  always @(posedge clk) begin
    char_item_t want;
    if (!rst && dout.valid && dout.ready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch("unexpected item", 32'(dout.char_code), 32'd0);
      end else begin
        want = expected_chars.pop_front();
        if (dout.char_code !== want.code)
          report_mismatch("char_code", 32'(dout.char_code), 32'(want.code));
        if (dout.last !== want.last)
          report_mismatch("last", 32'(dout.last), 32'(want.last));
        if (dout.overflow !== want.ovf)
          report_mismatch("overflow", 32'(dout.overflow), 32'(want.ovf));
        if (dout.char_count !== want.count)
          report_mismatch("char_count", 32'(dout.char_count), 32'(want.count));
      end
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (rst || (din.valid && din.ready) || (dout.valid && dout.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst           <= 1'b1;
    din.valid     <= 1'b0;
    din.value     <= '0;
    din.is_signed <= 1'b0;
    din.radix     <= '0;
    cfg.valid     <= 1'b0;
    cfg.data      <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_capacity();
    test_random();
    test_backpressure();
    test_lockstep();

    wait_for_drain();
    repeat (END_CYCLES) @(posedge clk);
    if (expected_chars.size() != 0)
      report_mismatch("missing items", 32'd0, 32'(expected_chars.size()));
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
